// ===== rtl/twq_pkg.sv =====
// Shared types and constants for the timed wakeup queue.
`default_nettype none

package twq_pkg;

    localparam int QueueDepth = 16;
    localparam int SlotW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int TimeW      = 64;
    localparam int IdW        = 8;
    localparam int KindW      = 3;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_SET_TIME = 1'b1;

    localparam logic [KindW-1:0] KIND_QUEUED   = 3'd0;
    localparam logic [KindW-1:0] KIND_WOKEN    = 3'd1;
    localparam logic [KindW-1:0] KIND_ACCEPTED = 3'd2;
    localparam logic [KindW-1:0] KIND_PAST     = 3'd3;
    localparam logic [KindW-1:0] KIND_FULL     = 3'd4;

    typedef struct packed {
        logic             op;
        logic [TimeW-1:0] time_value;
        logic [IdW-1:0]   waiter_id;
    } in_item_t;

    typedef struct packed {
        logic [KindW-1:0] event_kind;
        logic [IdW-1:0]   waiter_id_res;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        ID_ZERO,
        ID_ITEM,
        ID_BEST
    } id_sel_t;

    typedef struct packed {
        logic             load;
        logic             set_now;
        logic             store;
        logic             scan_start;
        logic             scan_step;
        logic             wake_best;
        logic             emit;
        logic [KindW-1:0] emit_kind;
        id_sel_t          emit_id;
        logic             emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_set;
        logic due_now;
        logic past;
        logic has_free;
        logic scan_done;
        logic best_found;
        logic emit_ok;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/twq_datapath.sv =====
// Datapath: current time, slot table, earliest-wakeup scan and result register.
`default_nettype none

module twq_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire twq_pkg::in_item_t   req,
    input  wire twq_pkg::ctrl_cmd_t  cmd,
    output twq_pkg::dp_status_t      status,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output twq_pkg::out_item_t       rsp
);

    twq_pkg::in_item_t                     item_reg;
    logic [twq_pkg::TimeW-1:0]             now_reg;
    logic [twq_pkg::TimeW-1:0]             wake_mem [twq_pkg::QueueDepth];
    logic [twq_pkg::IdW-1:0]               owner_mem [twq_pkg::QueueDepth];
    logic [twq_pkg::QueueDepth-1:0]        valid_reg;
    logic [twq_pkg::SlotW-1:0]             scan_idx_reg;
    logic                                  best_found_reg;
    logic [twq_pkg::SlotW-1:0]             best_idx_reg;
    logic [twq_pkg::TimeW-1:0]             best_time_reg;
    logic [twq_pkg::IdW-1:0]               best_owner_reg;
    twq_pkg::out_item_t                    rsp_reg;
    logic                                  rsp_valid_reg;

    logic                                  free_found;
    logic [twq_pkg::SlotW-1:0]             free_idx;
    logic [twq_pkg::TimeW-1:0]             rd_time;
    logic [twq_pkg::IdW-1:0]               rd_owner;
    logic                                  candidate;
    logic [twq_pkg::IdW-1:0]               emit_id;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = twq_pkg::QueueDepth - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = twq_pkg::SlotW'(i);
            end
        end
    end

    assign rd_time   = wake_mem[scan_idx_reg];
    assign rd_owner  = owner_mem[scan_idx_reg];
    assign candidate = valid_reg[scan_idx_reg] && (rd_time <= item_reg.time_value)
                       && (!best_found_reg || (rd_time < best_time_reg));

    always_comb
    begin
        unique case (cmd.emit_id)
            twq_pkg::ID_ITEM: emit_id = item_reg.waiter_id;
            twq_pkg::ID_BEST: emit_id = best_owner_reg;
            default:          emit_id = '0;
        endcase
    end

    assign status.is_set     = (item_reg.op == twq_pkg::OP_SET_TIME);
    assign status.due_now    = (item_reg.time_value <= now_reg);
    assign status.past       = (item_reg.time_value < now_reg);
    assign status.has_free   = free_found;
    assign status.scan_done  = (scan_idx_reg == twq_pkg::SlotW'(twq_pkg::QueueDepth - 1));
    assign status.best_found = best_found_reg;
    assign status.emit_ok    = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_now)
            begin
                now_reg <= item_reg.time_value;
            end
            if (cmd.store)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.wake_best)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (candidate)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.store)
        begin
            wake_mem[free_idx]  <= item_reg.time_value;
            owner_mem[free_idx] <= item_reg.waiter_id;
        end
        if (cmd.scan_step && candidate)
        begin
            best_idx_reg   <= scan_idx_reg;
            best_time_reg  <= rd_time;
            best_owner_reg <= rd_owner;
        end
        if (cmd.emit)
        begin
            rsp_reg.event_kind    <= cmd.emit_kind;
            rsp_reg.waiter_id_res <= emit_id;
            rsp_reg.last          <= cmd.emit_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/twq_ctrl.sv =====
// Controller: sequences decision, slot scans and result transfers per item.
`default_nettype none

module twq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire twq_pkg::dp_status_t status,
    output twq_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT_REG,
        S_EMIT_PAST,
        S_SCAN,
        S_SCAN_END,
        S_EMIT_WAKE,
        S_EMIT_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next     = state_reg;
        stall_next     = stall_reg;
        cmd            = '0;
        cmd.emit_kind  = twq_pkg::KIND_ACCEPTED;
        cmd.emit_id    = twq_pkg::ID_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !stall_reg)
                begin
                    cmd.load   = 1'b1;
                    stall_next = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.is_set)
                begin
                    state_next = S_EMIT_REG;
                end
                else if (status.past)
                begin
                    state_next = S_EMIT_PAST;
                end
                else
                begin
                    cmd.set_now    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_EMIT_REG:
            begin
                cmd.emit_id   = twq_pkg::ID_ITEM;
                cmd.emit_last = 1'b1;
                if (status.due_now)
                begin
                    cmd.emit_kind = twq_pkg::KIND_WOKEN;
                end
                else if (status.has_free)
                begin
                    cmd.emit_kind = twq_pkg::KIND_QUEUED;
                end
                else
                begin
                    cmd.emit_kind = twq_pkg::KIND_FULL;
                end
                if (status.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.store  = !status.due_now && status.has_free;
                    stall_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_PAST:
            begin
                cmd.emit_kind = twq_pkg::KIND_PAST;
                cmd.emit_last = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    stall_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = status.best_found ? S_EMIT_WAKE : S_EMIT_DONE;
            end
            S_EMIT_WAKE:
            begin
                cmd.emit_kind = twq_pkg::KIND_WOKEN;
                cmd.emit_id   = twq_pkg::ID_BEST;
                if (status.emit_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.wake_best  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_EMIT_DONE:
            begin
                cmd.emit_kind = twq_pkg::KIND_ACCEPTED;
                cmd.emit_last = 1'b1;
                if (status.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    stall_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

endmodule

`default_nettype wire

// ===== rtl/timed_wakeup_queue_unit.sv =====
// Top level of the timed wakeup queue: controller plus datapath.
//
// Request channel (req_valid, req_stall, req) carries one item per transfer:
// op 0 registers waiter_id to wake at time_value, op 1 sets the current time.
// Result channel (rsp_valid, rsp_stall, rsp) carries event_kind, waiter_id_res
// and last; last marks the final result of a request.
// One request is worked on at a time; req_stall is high from the transfer
// until its last result is loaded into the output register.
// Register request: the item is loaded in S_IDLE, checked in S_DECIDE and its
// result is loaded in S_EMIT_REG; the next request is taken back in S_IDLE.
// Set request: each pass walks all slots of the table one per cycle in S_SCAN;
// a found waiter is woken in S_EMIT_WAKE and a new pass starts, so a set that
// wakes k waiters makes k + 1 passes. A rejected set goes to S_EMIT_PAST.
// A stall on the result channel holds the output register and pauses the
// sequencer when it next has a result to load, until the pending result is transferred.
// Reset clears the current time to zero and empties the table; no clearing
// pass is needed and the first request is taken right after reset.
`default_nettype none

module timed_wakeup_queue_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire twq_pkg::in_item_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output twq_pkg::out_item_t     rsp
);

    twq_pkg::ctrl_cmd_t  cmd;
    twq_pkg::dp_status_t status;

    twq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    twq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
